// ----- hw/rtl/pl_max_pkg.sv -----
// ----------------------------------------------------------------------------
// Positional list package
// Sizes, request and status codes, and the word and control types shared by
// the list cells and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package pl_max_pkg;

  localparam int DEPTH       = 128;
  localparam int VALUE_WIDTH = 16;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_QUERY  = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } cell_op_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_HOLD = 2'd2
  } state_e;

  typedef struct packed {
    logic [1:0]             req_type;
    logic [IDX_W-1:0]       position;
    logic [VALUE_WIDTH-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [CNT_W-1:0]       entry_count;
    logic [VALUE_WIDTH-1:0] max_value;
    logic [IDX_W-1:0]       max_index;
    logic                   max_valid;
    logic [1:0]             status;
  } out_word_t;

  // Broadcast to every cell: the shift to apply and the current fill.
  typedef struct packed {
    cell_op_e               op;
    logic [IDX_W-1:0]       pos;
    logic [VALUE_WIDTH-1:0] value;
    logic [CNT_W-1:0]       count;
  } cell_ctrl_t;

  // Running maximum handed from one cell to the next.
  typedef struct packed {
    logic                   valid;
    logic [VALUE_WIDTH-1:0] value;
    logic [IDX_W-1:0]       index;
  } max_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pl_max_cell.sv -----
// ----------------------------------------------------------------------------
// Positional list cell
// Holds one list entry, shifts it with its neighbours on insert or delete, and
// folds its entry into the running maximum passed along the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module pl_max_cell (
  input  logic                               clk_i,
  input  pl_max_pkg::cell_ctrl_t             ctrl_i,
  input  logic [pl_max_pkg::IDX_W-1:0]       cell_idx_i,
  input  logic [pl_max_pkg::VALUE_WIDTH-1:0] left_val_i,
  input  logic [pl_max_pkg::VALUE_WIDTH-1:0] right_val_i,
  input  pl_max_pkg::max_t                   left_max_i,
  output logic [pl_max_pkg::VALUE_WIDTH-1:0] val_o,
  output pl_max_pkg::max_t                   max_o
);
  import pl_max_pkg::*;

  logic [VALUE_WIDTH-1:0] val_q, val_d;
  max_t                   max_q, max_d;
  logic                   occupied;

  assign occupied = ({1'b0, cell_idx_i} < ctrl_i.count);

  always_comb begin
    val_d = val_q;
    case (ctrl_i.op)
      OP_INSERT: begin
        if (cell_idx_i > ctrl_i.pos) begin
          val_d = left_val_i;
        end else if (cell_idx_i == ctrl_i.pos) begin
          val_d = ctrl_i.value;
        end
      end
      OP_DELETE: begin
        if (cell_idx_i >= ctrl_i.pos) begin
          val_d = right_val_i;
        end
      end
      default: begin
        val_d = val_q;
      end
    endcase
  end

  // Ties go to the later cell, so the last index holding the maximum wins.
  always_comb begin
    max_d = left_max_i;
    if (occupied && (!left_max_i.valid || (val_q >= left_max_i.value))) begin
      max_d.valid = 1'b1;
      max_d.value = val_q;
      max_d.index = cell_idx_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    max_q <= max_d;
  end

  assign val_o = val_q;
  assign max_o = max_q;

endmodule

`default_nettype wire

// ----- hw/rtl/positional_list_with_max_query_top.sv -----
// ----------------------------------------------------------------------------
// Positional list with maximum query
// Ordered list held in a chain of cells; insert and delete shift the whole chain
// at once, and every request returns the count and the last maximum entry.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake               word
//   in        input       in_valid_i / in_ready_o   in_word_t
//   out       output      out_valid_o / out_ready_i out_word_t
//
// The chain shifts at the edge that accepts a request. The
// running maximum then ripples one cell per cycle down the chain, so a result
// is ready once it has passed every cell; no new request is taken until that
// result has been loaded into the output register.
// Reset clears the entry count; cell contents are not cleared.
// A result waits in the output register while the next request is worked on.
//
`default_nettype none

module positional_list_with_max_query_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pl_max_pkg::in_word_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pl_max_pkg::out_word_t out_data_o
);
  import pl_max_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] scan_q, scan_d;
  logic [1:0]       status_q, status_d;
  logic             out_valid_q, out_valid_d;
  out_word_t        out_q, out_d;

  logic             accept;
  logic             scan_done;
  logic             out_load;
  cell_ctrl_t       ctrl;
  cell_op_e         op;
  logic [CNT_W-1:0] pos_ext;

  logic [VALUE_WIDTH-1:0] val_w   [DEPTH];
  max_t                   max_w   [DEPTH];

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign pos_ext    = {{(CNT_W-IDX_W){1'b0}}, in_data_i.position};
  assign scan_done  = (scan_q == CNT_W'(DEPTH));

  // Request decoding against the current fill.
  always_comb begin
    op       = OP_HOLD;
    status_d = ST_OK;
    count_d  = count_q;
    if (in_data_i.req_type == REQ_INSERT) begin
      if (count_q >= CNT_W'(DEPTH)) begin
        status_d = ST_FULL;
      end else if (pos_ext > count_q) begin
        status_d = ST_RANGE;
      end else begin
        op      = OP_INSERT;
        count_d = count_q + 1'b1;
      end
    end else if (in_data_i.req_type == REQ_DELETE) begin
      if (pos_ext >= count_q) begin
        status_d = ST_RANGE;
      end else begin
        op      = OP_DELETE;
        count_d = count_q - 1'b1;
      end
    end
  end

  always_comb begin
    ctrl.op    = accept ? op : OP_HOLD;
    ctrl.pos   = in_data_i.position;
    ctrl.value = in_data_i.value;
    ctrl.count = count_q;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_val;
    logic [VALUE_WIDTH-1:0] right_val;
    max_t                   left_max;

    if (i == 0) begin : g_first
      assign left_val = '0;
      assign left_max = '0;
    end else begin : g_mid
      assign left_val = val_w[i-1];
      assign left_max = max_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_val = val_w[i];
    end else begin : g_inner
      assign right_val = val_w[i+1];
    end

    pl_max_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .cell_idx_i  (IDX_W'(i)),
      .left_val_i  (left_val),
      .right_val_i (right_val),
      .left_max_i  (left_max),
      .val_o       (val_w[i]),
      .max_o       (max_w[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    scan_d      = scan_q;
    out_load    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SCAN;
          scan_d  = '0;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          if (!out_valid_q || out_ready_i) begin
            out_load = 1'b1;
            state_d  = S_IDLE;
          end else begin
            state_d = S_HOLD;
          end
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      S_HOLD: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // The end of the chain carries the maximum over all occupied cells.
  always_comb begin
    out_d             = out_q;
    out_valid_d       = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d       = 1'b1;
      out_d.entry_count = count_q;
      out_d.max_valid   = max_w[DEPTH-1].valid;
      out_d.max_value   = max_w[DEPTH-1].valid ? max_w[DEPTH-1].value : '0;
      out_d.max_index   = max_w[DEPTH-1].valid ? max_w[DEPTH-1].index : '0;
      out_d.status      = status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= accept ? count_d : count_q;
      scan_q      <= scan_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- dv/positional_list_with_max_query_top_tb.sv -----
// ----------------------------------------------------------------------------
// Positional list with maximum query testbench
// Drives insert, delete and query words through the valid/ready input with
// bursty gaps, stalls the output on its own pattern, and checks each result
// word against a given value or against a behavioural list of accepted words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module positional_list_with_max_query_top_tb;
  import pl_max_pkg::*;

  localparam int           RANDOM_WORDS = 1300;
  localparam int           CYCLE_LIMIT  = 2_000_000;
  localparam logic [1:0]   REQ_SPARE    = 2'd3;

  typedef struct {
    logic [1:0]             req;
    int                     pos;
    logic [VALUE_WIDTH-1:0] val;
    bit                     typed;
    out_word_t              res;
  } dir_row_t;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_word_t  in_data_i   = '0;
  logic      out_ready_i = 1'b0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_word_t out_data_o;

  // Behavioural copy of the list.
  logic [VALUE_WIDTH-1:0] list_mem [DEPTH];
  int                     list_len = 0;

  out_word_t pending_results [$];
  dir_row_t  dir_rows [$];
  int        fail_count = 0;
  int        cycle_count = 0;
  int        burst_left = 0;
  int        rx_left = 0;

  positional_list_with_max_query_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic out_word_t apply_request(in_word_t w);
    out_word_t              r;
    int                     i;
    int                     top_at;
    logic [VALUE_WIDTH-1:0] top;
    status_e                st;
    st = ST_OK;
    if (w.req_type == REQ_INSERT) begin
      if (list_len >= DEPTH) begin
        st = ST_FULL;
      end else if (int'(w.position) > list_len) begin
        st = ST_RANGE;
      end else begin
        for (i = list_len; i > int'(w.position); i--) list_mem[i] = list_mem[i-1];
        list_mem[w.position] = w.value;
        list_len++;
      end
    end else if (w.req_type == REQ_DELETE) begin
      if (int'(w.position) >= list_len) begin
        st = ST_RANGE;
      end else begin
        for (i = int'(w.position); i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
        list_len--;
      end
    end
    top    = '0;
    top_at = 0;
    // Later entries win a tie, hence the greater-or-equal test.
    for (i = 0; i < list_len; i++) begin
      if (i == 0 || list_mem[i] >= top) begin
        top    = list_mem[i];
        top_at = i;
      end
    end
    r.entry_count = CNT_W'(list_len);
    r.max_value   = top;
    r.max_index   = IDX_W'(top_at);
    r.max_valid   = (list_len > 0);
    r.status      = st;
    return r;
  endfunction

  function automatic out_word_t mk_result(int cnt, logic [VALUE_WIDTH-1:0] mv, int mi,
                                          bit vld, status_e st);
    out_word_t r;
    r.entry_count = CNT_W'(cnt);
    r.max_value   = mv;
    r.max_index   = IDX_W'(mi);
    r.max_valid   = vld;
    r.status      = st;
    return r;
  endfunction

  function automatic dir_row_t mk_row(logic [1:0] rq, int p, logic [VALUE_WIDTH-1:0] v,
                                      bit typed, out_word_t res);
    dir_row_t d;
    d.req   = rq;
    d.pos   = p;
    d.val   = v;
    d.typed = typed;
    d.res   = res;
    return d;
  endfunction

  task automatic report_mismatch(string field, longint unsigned want, longint unsigned got);
    $display("ERROR @%0t: %s expected %0h, got %0h", $realtime, field, want, got);
    fail_count++;
  endtask

  // Presents one word, waits for its acceptance and files the expected result.
  task automatic send_word(in_word_t w, bit typed, out_word_t typed_res);
    int        gap;
    out_word_t predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 10) : $urandom_range(100, 160);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = apply_request(w);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // Receiver: long open stretches, short stalls and the odd long one.
  always @(negedge clk_i) begin
    int pick;
    if (rx_left != 0) begin
      rx_left <= rx_left - 1;
    end else begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        out_ready_i <= 1'b1;
        rx_left     <= $urandom_range(1, 400);
      end else if (pick < 9) begin
        out_ready_i <= 1'b0;
        rx_left     <= $urandom_range(1, 40);
      end else begin
        out_ready_i <= 1'b0;
        rx_left     <= $urandom_range(100, 150);
      end
    end
  end

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("ERROR @%0t: result word with nothing expected", $realtime);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.entry_count !== want.entry_count)
          report_mismatch("entry_count", want.entry_count, out_data_o.entry_count);
        if (out_data_o.max_value !== want.max_value)
          report_mismatch("max_value", want.max_value, out_data_o.max_value);
        if (out_data_o.max_index !== want.max_index)
          report_mismatch("max_index", want.max_index, out_data_o.max_index);
        if (out_data_o.max_valid !== want.max_valid)
          report_mismatch("max_valid", want.max_valid, out_data_o.max_valid);
        if (out_data_o.status !== want.status)
          report_mismatch("status", want.status, out_data_o.status);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    in_word_t  w;
    int        sent;
    int        mode;
    int        phase_len;
    int        pick;
    logic [VALUE_WIDTH-1:0] tie_vals [4];
    tie_vals = '{16'h0000, 16'hFFFF, 16'h8000, 16'h1234};

    // Empty list, range errors, a tie at the top of the value range, the
    // spare request code, and a drain back to empty.
    dir_rows.push_back(mk_row(REQ_QUERY,  0,   16'h0000, 1, mk_result(0, 0, 0, 0, ST_OK)));
    dir_rows.push_back(mk_row(REQ_DELETE, 0,   16'h0000, 1, mk_result(0, 0, 0, 0, ST_RANGE)));
    dir_rows.push_back(mk_row(REQ_INSERT, 1,   16'h0005, 1, mk_result(0, 0, 0, 0, ST_RANGE)));
    dir_rows.push_back(mk_row(REQ_INSERT, 0,   16'hFFFF, 1,
                              mk_result(1, 16'hFFFF, 0, 1, ST_OK)));
    dir_rows.push_back(mk_row(REQ_INSERT, 0,   16'h0000, 1,
                              mk_result(2, 16'hFFFF, 1, 1, ST_OK)));
    dir_rows.push_back(mk_row(REQ_INSERT, 2,   16'hFFFF, 1,
                              mk_result(3, 16'hFFFF, 2, 1, ST_OK)));
    dir_rows.push_back(mk_row(REQ_INSERT, 127, 16'h0001, 1,
                              mk_result(3, 16'hFFFF, 2, 1, ST_RANGE)));
    dir_rows.push_back(mk_row(REQ_SPARE,  127, 16'hFFFF, 1,
                              mk_result(3, 16'hFFFF, 2, 1, ST_OK)));
    dir_rows.push_back(mk_row(REQ_QUERY,  0,   16'h0000, 1,
                              mk_result(3, 16'hFFFF, 2, 1, ST_OK)));
    dir_rows.push_back(mk_row(REQ_DELETE, 127, 16'h0000, 1,
                              mk_result(3, 16'hFFFF, 2, 1, ST_RANGE)));
    dir_rows.push_back(mk_row(REQ_DELETE, 3,   16'h0000, 1,
                              mk_result(3, 16'hFFFF, 2, 1, ST_RANGE)));
    dir_rows.push_back(mk_row(REQ_DELETE, 2,   16'h0000, 1,
                              mk_result(2, 16'hFFFF, 1, 1, ST_OK)));
    dir_rows.push_back(mk_row(REQ_INSERT, 2,   16'h7FFF, 0, '0));
    dir_rows.push_back(mk_row(REQ_INSERT, 1,   16'h8000, 0, '0));
    dir_rows.push_back(mk_row(REQ_DELETE, 0,   16'h0000, 0, '0));
    dir_rows.push_back(mk_row(REQ_INSERT, 0,   16'h0001, 0, '0));
    dir_rows.push_back(mk_row(REQ_DELETE, 3,   16'h0000, 0, '0));
    dir_rows.push_back(mk_row(REQ_DELETE, 0,   16'h0000, 0, '0));
    dir_rows.push_back(mk_row(REQ_DELETE, 0,   16'h0000, 0, '0));
    dir_rows.push_back(mk_row(REQ_DELETE, 0,   16'h0000, 1, mk_result(0, 0, 0, 0, ST_OK)));
    dir_rows.push_back(mk_row(REQ_DELETE, 0,   16'h0000, 1, mk_result(0, 0, 0, 0, ST_RANGE)));

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[k]) begin
      w.req_type = dir_rows[k].req;
      w.position = IDX_W'(dir_rows[k].pos);
      w.value    = dir_rows[k].val;
      send_word(w, dir_rows[k].typed, dir_rows[k].res);
    end

    // Random phases: filling (reaches a full list first time round),
    // draining, and mixed traffic.
    sent = 0;
    mode = 0;
    phase_len = 200;
    while (sent < RANDOM_WORDS) begin
      if (phase_len > RANDOM_WORDS - sent) phase_len = RANDOM_WORDS - sent;
      repeat (phase_len) begin
        pick = $urandom_range(0, 99);
        case (mode)
          0:       w.req_type = (pick < 85) ? REQ_INSERT : (pick < 95) ? REQ_DELETE : REQ_QUERY;
          1:       w.req_type = (pick < 85) ? REQ_DELETE : (pick < 95) ? REQ_INSERT : REQ_QUERY;
          default: w.req_type = (pick < 45) ? REQ_INSERT : (pick < 90) ? REQ_DELETE : REQ_QUERY;
        endcase
        if (w.req_type == REQ_QUERY && $urandom_range(0, 3) == 0) w.req_type = REQ_SPARE;
        if ($urandom_range(0, 9) == 0)
          w.position = IDX_W'($urandom_range(0, DEPTH - 1));
        else if (w.req_type == REQ_INSERT)
          w.position = IDX_W'($urandom_range(0, (list_len < DEPTH) ? list_len : DEPTH - 1));
        else if (w.req_type == REQ_DELETE && list_len > 0)
          w.position = IDX_W'($urandom_range(0, list_len - 1));
        else
          w.position = IDX_W'($urandom_range(0, DEPTH - 1));
        pick = $urandom_range(0, 9);
        if (pick < 7)
          w.value = VALUE_WIDTH'($urandom);
        else
          w.value = tie_vals[$urandom_range(0, 3)];
        send_word(w, 1'b0, '0);
        sent++;
      end
      mode      = $urandom_range(0, 2);
      phase_len = $urandom_range(40, 200);
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2 * DEPTH) @(posedge clk_i);

    if (pending_results.size() != 0) begin
      $display("ERROR @%0t: %0d result words never arrived", $realtime,
               pending_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- positional_list_with_max_query_top.f -----
hw/rtl/pl_max_pkg.sv
hw/rtl/pl_max_cell.sv
hw/rtl/positional_list_with_max_query_top.sv
dv/positional_list_with_max_query_top_tb.sv
